### rtl/sndenv_pkg.sv
// ----------------------------------------------------------------------------
// sndenv_pkg
// Shared types, request codes and the envelope level table for the sound
// envelope generator.
// ----------------------------------------------------------------------------
package sndenv_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_TICK_INT = 2'd1,
    REQ_TICK_EXT = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_e;

  // control byte bit positions
  localparam int unsigned CtlEnableBit = 7;
  localparam int unsigned CtlExtClkBit = 5;
  localparam int unsigned CtlThreeBit  = 4;
  localparam int unsigned CtlShapeHi   = 3;
  localparam int unsigned CtlShapeLo   = 1;
  localparam int unsigned CtlInvertBit = 0;

  localparam logic [3:0] LevelMax      = 4'd15;
  localparam logic [3:0] LevelMaxThree = 4'd14;
  localparam logic [3:0] ThreeBitMask  = 4'hE;

  typedef struct packed {
    logic [3:0] left;
    logic [3:0] right;
    logic       active;
  } levels_t;

  // level table: eight shapes, odd shapes repeat
  function automatic logic [3:0] rom_level(input logic [2:0] shape,
                                           input logic [1:0] phase,
                                           input logic [3:0] pos,
                                           input logic       three);
    logic [3:0] v;
    v = 4'd0;
    case (shape)
      3'd1: v = (phase == 2'd0) ? LevelMax : 4'd0;
      3'd2, 3'd3: v = (phase == 2'd0) ? LevelMax - pos : 4'd0;
      3'd4, 3'd5: begin
        if (phase == 2'd0) begin
          v = pos;
        end else if (phase == 2'd1) begin
          v = LevelMax - pos;
        end else begin
          v = 4'd0;
        end
      end
      3'd6, 3'd7: v = (phase == 2'd0) ? pos : 4'd0;
      default: v = 4'd0;
    endcase
    if (three) begin
      v = v & ThreeBitMask;
    end
    return v;
  endfunction

  // number of 16-position phases in a shape
  function automatic logic [1:0] shape_phases(input logic [2:0] shape);
    return (shape[2:1] == 2'b10) ? 2'd2 : 2'd1;
  endfunction

endpackage

### rtl/sndenv_engine.sv
// ----------------------------------------------------------------------------
// sndenv_engine
// Envelope state and its combinational update for one write or tick.
// ----------------------------------------------------------------------------
module sndenv_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [1:0]           req_i,
  input  logic [7:0]           byte_i,
  output sndenv_pkg::levels_t  next_o
);
  import sndenv_pkg::*;

  logic       en_q, en_d;
  logic       pend_q, pend_d;
  logic [7:0] pbyte_q, pbyte_d;
  logic       rdy_q, rdy_d;
  logic       done_q, done_d;
  logic [1:0] phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic [2:0] shape_q, shape_d;
  logic       inv_q, inv_d;
  logic       ext_q, ext_d;
  logic       three_q, three_d;
  logic [3:0] left_q, left_d;
  logic [3:0] right_q, right_d;

  logic       load;
  logic [7:0] load_byte;
  logic       upd;
  logic [4:0] sum;
  logic [1:0] ph;
  logic [3:0] lvl;
  logic       tick_ok;

  always_comb begin
    en_d      = en_q;
    pend_d    = pend_q;
    pbyte_d   = pbyte_q;
    rdy_d     = rdy_q;
    done_d    = done_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    shape_d   = shape_q;
    inv_d     = inv_q;
    ext_d     = ext_q;
    three_d   = three_q;
    left_d    = left_q;
    right_d   = right_q;
    load      = 1'b0;
    load_byte = byte_i;
    upd       = 1'b0;
    sum       = {1'b0, pos_q} + (three_q ? 5'd2 : 5'd1);
    ph        = phase_q + 2'd1;
    lvl       = 4'd0;
    tick_ok   = 1'b0;

    case (req_e'(req_i))
      REQ_WRITE: begin
        if (byte_i[CtlEnableBit] || en_q) begin
          en_d = byte_i[CtlEnableBit];
          if (!byte_i[CtlEnableBit]) begin
            done_d = 1'b1;
            rdy_d  = 1'b1;
          end else begin
            three_d = byte_i[CtlThreeBit];
            if (rdy_q) begin
              load   = 1'b1;
              pend_d = 1'b0;
            end else begin
              upd     = 1'b1;
              pend_d  = 1'b1;
              pbyte_d = byte_i;
            end
          end
        end
      end
      REQ_TICK_INT, REQ_TICK_EXT: begin
        tick_ok = en_q && (ext_q == (req_i == REQ_TICK_EXT)) && !done_q;
        if (tick_ok) begin
          if (sum[4]) begin
            // wrapped past the end of a phase
            if (ph == shape_phases(shape_q)) begin
              rdy_d = 1'b1;
              if (!shape_q[0]) begin
                done_d = 1'b1;
              end else begin
                ph = 2'd0;
              end
            end else begin
              rdy_d = 1'b0;
            end
            phase_d = ph;
          end else begin
            rdy_d = 1'b0;
          end
          pos_d = sum[3:0];
          if (pend_q && rdy_d) begin
            pend_d    = 1'b0;
            load      = 1'b1;
            load_byte = pbyte_q;
          end else begin
            upd = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (load) begin
      phase_d = 2'd0;
      pos_d   = 4'd0;
      shape_d = load_byte[CtlShapeHi:CtlShapeLo];
      inv_d   = load_byte[CtlInvertBit];
      ext_d   = load_byte[CtlExtClkBit];
      three_d = load_byte[CtlThreeBit];
      en_d    = load_byte[CtlEnableBit];
      if (load_byte[CtlEnableBit]) begin
        done_d = 1'b0;
      end else begin
        done_d = 1'b1;
        rdy_d  = 1'b1;
      end
    end

    if (load || upd) begin
      if (done_d && !shape_d[0]) begin
        lvl = 4'd0;
      end else begin
        lvl = rom_level(shape_d, phase_d, pos_d, three_d);
      end
      left_d  = lvl;
      right_d = inv_d ? ((three_d ? LevelMaxThree : LevelMax) - lvl) : lvl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q    <= 1'b0;
      pend_q  <= 1'b0;
      pbyte_q <= 8'd0;
      rdy_q   <= 1'b1;
      done_q  <= 1'b1;
      phase_q <= 2'd0;
      pos_q   <= 4'd0;
      shape_q <= 3'd0;
      inv_q   <= 1'b0;
      ext_q   <= 1'b0;
      three_q <= 1'b0;
      left_q  <= 4'd0;
      right_q <= 4'd0;
    end else if (fire_i) begin
      en_q    <= en_d;
      pend_q  <= pend_d;
      pbyte_q <= pbyte_d;
      rdy_q   <= rdy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shape_q <= shape_d;
      inv_q   <= inv_d;
      ext_q   <= ext_d;
      three_q <= three_d;
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign next_o.left   = left_d;
  assign next_o.right  = right_d;
  assign next_o.active = en_d;

endmodule

### rtl/sound_envelope_generator_core.sv
// ----------------------------------------------------------------------------
// sound_envelope_generator_core
// Envelope generator: control writes and clock ticks in, levels out.
// ----------------------------------------------------------------------------
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+----------------------------------
//  in      | in_valid_i  | in_stall_o   | req_type_i, control_byte_i
//  out     | out_valid_o | out_stall_i  | left_level_o, right_level_o,
//          |             |              | active_o
//
//  one item per cycle while out is not stalled; an input transfer reaches the
//  result via the input register, then the result register around the update.
//  reset clears the envelope state and both valid flags.
//  a stalled result holds while one more item waits in the input register;
//  in_stall_o rises only when both registers are full and out is stalled.
// ----------------------------------------------------------------------------
module sound_envelope_generator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [7:0] control_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] left_level_o,
  output logic [3:0] right_level_o,
  output logic       active_o
);
  import sndenv_pkg::*;

  logic       in_vld_q;
  logic [1:0] req_q;
  logic [7:0] byte_q;
  logic       out_vld_q;
  levels_t    res_q;
  levels_t    next;
  logic       adv;
  logic       fire;
  logic       in_xfer;

  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  sndenv_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req_q),
    .byte_i (byte_q),
    .next_o (next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (fire) begin
        in_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q  <= req_type_i;
      byte_q <= control_byte_i;
    end
    if (fire) begin
      res_q <= next;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign left_level_o  = res_q.left;
  assign right_level_o = res_q.right;
  assign active_o      = res_q.active;

endmodule
